>>> rtl/core/logic_analyzer_command_parser_defines.svh
// Assertion macros shared by the command parser modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef LOGIC_ANALYZER_COMMAND_PARSER_DEFINES_SVH
`define LOGIC_ANALYZER_COMMAND_PARSER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define LACP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define LACP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define LACP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lacp_pkg.sv
// Shared types and constants of the logic analyzer command parser.
// Used by the command core, the output buffer, the top level, the result checker and the testbench.
package lacp_pkg;

  // Reset values of the capture settings.
  localparam int unsigned DEF_DIVIDER = 143;
  localparam int unsigned DEF_SAMPLES = 4096;

  // Long command opcodes.
  localparam logic [7:0] OP_SET_DIVIDER = 8'h80;
  localparam logic [7:0] OP_SET_COUNTS  = 8'h81;
  localparam logic [7:0] OP_SET_FLAGS   = 8'h82;
  localparam logic [7:0] OP_TRIG_MASK   = 8'hc0;
  localparam logic [7:0] OP_TRIG_VALUE  = 8'hc1;
  localparam logic [7:0] OP_TRIG_SETUP  = 8'hc2;

  // Short command bytes.
  localparam logic [7:0] SHORT_RESET    = 8'h00;
  localparam logic [7:0] SHORT_RUN      = 8'h01;
  localparam logic [7:0] SHORT_ID       = 8'h02;
  localparam logic [7:0] SHORT_META     = 8'h04;

  // Number of payload bytes that follow a long opcode.
  localparam logic [2:0] LONG_PAYLOAD   = 3'd4;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_RESET = 3'd1,
    ACT_RUN   = 3'd2,
    ACT_ID    = 3'd3,
    ACT_META  = 3'd4
  } action_t;

  typedef struct packed {
    logic [23:0] sample_divider;
    logic [18:0] read_samples;
    logic [18:0] delay_samples;
    logic [31:0] capture_flags;
    logic [31:0] trig_mask;
    logic [31:0] trig_value;
    logic [31:0] trig_setup;
  } settings_t;

  typedef struct packed {
    action_t   action;
    settings_t settings;
  } lacp_result_t;

endpackage

>>> rtl/core/lacp_ifs.sv
// Valid/ready channel interfaces of the command parser: host bytes in, results out.
// Depends on nothing but the field widths of the protocol.
interface lacp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] host_byte;

  modport source (output valid, output host_byte, input ready);
  modport sink   (input valid, input host_byte, output ready);
endinterface

interface lacp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [23:0] sample_divider;
  logic [18:0] read_samples;
  logic [18:0] delay_samples;
  logic [31:0] capture_flags;
  logic [31:0] trig_mask;
  logic [31:0] trig_value;
  logic [31:0] trig_setup;

  modport source (output valid, output action, output sample_divider, output read_samples,
                  output delay_samples, output capture_flags, output trig_mask,
                  output trig_value, output trig_setup, input ready);
  modport sink   (input valid, input action, input sample_divider, input read_samples,
                  input delay_samples, input capture_flags, input trig_mask,
                  input trig_value, input trig_setup, output ready);
endinterface

>>> rtl/core/logic_analyzer_command_parser.sv
// Top level of the logic analyzer command parser: one host byte in, one result out.
// Depends on lacp_pkg, lacp_ifs, lacp_cmd_core and lacp_out_buf.

// Each accepted host byte produces exactly one result request, which is registered in
// the output buffer before it appears on the output channel. The parser takes one byte
// per clock while the buffer has room: the decode of a byte and the update of the
// settings registers happen in the same cycle in the command core, and the result goes
// into a two-entry output buffer. The input stays ready while the output register holds
// a result that has not been taken; it drops only when both buffer entries are full, so
// a stall on the output side is felt at the input after two results. Long commands are
// an opcode byte with bit 7 set followed by four payload bytes; the command takes effect
// on the fifth byte, and all five bytes give the action none. Every result carries the
// settings as they stand after its byte.
module logic_analyzer_command_parser
  import lacp_pkg::*;
#(
  parameter int unsigned DEFAULT_DIVIDER = DEF_DIVIDER,
  parameter int unsigned DEFAULT_SAMPLES = DEF_SAMPLES
) (
  input logic        clk,
  input logic        rst_n,
  lacp_in_if.sink    in_ch,
  lacp_out_if.source out_ch
);

  logic         take;
  logic         buf_ready;
  lacp_result_t core_res;
  lacp_result_t out_res;

  // A byte is taken whenever the buffer has room for its result.
  assign in_ch.ready = buf_ready;
  assign take        = in_ch.valid && buf_ready;

  lacp_cmd_core #(
    .DEFAULT_DIVIDER (DEFAULT_DIVIDER),
    .DEFAULT_SAMPLES (DEFAULT_SAMPLES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .host_byte (in_ch.host_byte),
    .res       (core_res)
  );

  lacp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (take),
    .push_ready (buf_ready),
    .push_data  (core_res),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_res)
  );

  // Spread the buffered result over the output channel fields.
  assign out_ch.action         = out_res.action;
  assign out_ch.sample_divider = out_res.settings.sample_divider;
  assign out_ch.read_samples   = out_res.settings.read_samples;
  assign out_ch.delay_samples  = out_res.settings.delay_samples;
  assign out_ch.capture_flags  = out_res.settings.capture_flags;
  assign out_ch.trig_mask      = out_res.settings.trig_mask;
  assign out_ch.trig_value     = out_res.settings.trig_value;
  assign out_ch.trig_setup     = out_res.settings.trig_setup;

endmodule

>>> rtl/core/lacp_cmd_core.sv
// Command decoder and settings registers of the command parser.
// Depends on lacp_pkg and the assertion macros in logic_analyzer_command_parser_defines.svh.
`include "logic_analyzer_command_parser_defines.svh"

module lacp_cmd_core
  import lacp_pkg::*;
#(
  parameter int unsigned DEFAULT_DIVIDER = DEF_DIVIDER,
  parameter int unsigned DEFAULT_SAMPLES = DEF_SAMPLES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         take,
  input  logic [7:0]   host_byte,
  output lacp_result_t res
);

  localparam settings_t SET_DEFAULT = '{
    sample_divider: 24'(DEFAULT_DIVIDER),
    read_samples:   19'(DEFAULT_SAMPLES),
    delay_samples:  19'(DEFAULT_SAMPLES),
    capture_flags:  32'd0,
    trig_mask:      32'd0,
    trig_value:     32'd0,
    trig_setup:     32'd0
  };

  logic [7:0]  opcode_r, opcode_nxt;
  logic [7:0]  pay_r [3];
  logic [7:0]  pay_nxt [3];
  logic [2:0]  held_r, held_nxt;
  settings_t   set_r, set_nxt;
  action_t     action;
  logic [1:0]  pay_idx;
  logic [31:0] word;
  logic [16:0] lo_inc;
  logic [16:0] hi_inc;

  // The fourth payload byte completes the word straight from the input.
  assign word    = {host_byte, pay_r[2], pay_r[1], pay_r[0]};
  assign lo_inc  = {1'b0, pay_r[1], pay_r[0]} + 17'd1;
  assign hi_inc  = {1'b0, host_byte, pay_r[2]} + 17'd1;
  assign pay_idx = held_r[1:0] - 2'd1;

  always_comb begin
    opcode_nxt = opcode_r;
    pay_nxt    = pay_r;
    held_nxt   = held_r;
    set_nxt    = set_r;
    action     = ACT_NONE;
    if (held_r != 3'd0) begin
      if (held_r == LONG_PAYLOAD) begin
        held_nxt = 3'd0;
        unique case (opcode_r)
          OP_SET_DIVIDER: set_nxt.sample_divider = word[23:0];
          OP_SET_COUNTS: begin
            set_nxt.read_samples  = {lo_inc, 2'b00};
            set_nxt.delay_samples = {hi_inc, 2'b00};
          end
          OP_SET_FLAGS:  set_nxt.capture_flags = word;
          OP_TRIG_MASK:  set_nxt.trig_mask     = word;
          OP_TRIG_VALUE: set_nxt.trig_value    = word;
          OP_TRIG_SETUP: set_nxt.trig_setup    = word;
          default: ;
        endcase
      end else begin
        pay_nxt[pay_idx] = host_byte;
        held_nxt         = held_r + 3'd1;
      end
    end else if (host_byte[7]) begin
      opcode_nxt = host_byte;
      held_nxt   = 3'd1;
    end else begin
      unique case (host_byte)
        SHORT_RESET: begin
          set_nxt = SET_DEFAULT;
          action  = ACT_RESET;
        end
        SHORT_RUN:  action = ACT_RUN;
        SHORT_ID:   action = ACT_ID;
        SHORT_META: action = ACT_META;
        default: ;
      endcase
    end
  end

  // The result carries the settings as they stand after this byte.
  assign res = '{action: action, settings: set_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 3'd0;
      set_r  <= SET_DEFAULT;
    end else if (take) begin
      held_r <= held_nxt;
      set_r  <= set_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      opcode_r <= opcode_nxt;
      pay_r    <= pay_nxt;
    end
  end

  `LACP_ASSERT_ALWAYS(a_held_range, held_r <= LONG_PAYLOAD, "long command byte count out of range")
  `LACP_ASSERT_SAME(a_long_no_action, take && held_r != 3'd0, res.action == ACT_NONE, "action inside long command")
  `LACP_ASSERT_NEXT(a_reset_defaults, take && held_r == 3'd0 && host_byte == SHORT_RESET, set_r == SET_DEFAULT, "reset command did not restore defaults")

endmodule

>>> rtl/core/lacp_out_buf.sv
// Two-entry result buffer: an output register with a skid register behind it.
// Depends on lacp_pkg and the assertion macros in logic_analyzer_command_parser_defines.svh.
`include "logic_analyzer_command_parser_defines.svh"

module lacp_out_buf
  import lacp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         push_ready,
  input  lacp_result_t push_data,
  output logic         out_valid,
  input  logic         out_ready,
  output lacp_result_t out_data
);

  logic         out_vld_r, out_vld_nxt;
  logic         skid_vld_r, skid_vld_nxt;
  lacp_result_t out_data_r, out_data_nxt;
  lacp_result_t skid_data_r, skid_data_nxt;
  logic         pop;

  assign pop        = out_vld_r && out_ready;
  assign push_ready = !skid_vld_r;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    skid_vld_nxt  = skid_vld_r;
    out_data_nxt  = out_data_r;
    skid_data_nxt = skid_data_r;
    if (skid_vld_r) begin
      if (pop) begin
        out_data_nxt = skid_data_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_data_nxt = push_data;
        out_vld_nxt  = 1'b1;
      end else begin
        skid_data_nxt = push_data;
        skid_vld_nxt  = 1'b1;
      end
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  `LACP_ASSERT_SAME(a_skid_behind_main, skid_vld_r, out_vld_r, "skid entry without output entry")
  `LACP_ASSERT_NEXT(a_stall_fills_skid, push && out_vld_r && !out_ready, skid_vld_r, "stalled request was not parked")
  `LACP_ASSERT_NEXT(a_skid_moves_up, pop && skid_vld_r, out_vld_r && out_data_r == $past(skid_data_r), "skid entry lost")

endmodule

>>> verif/lacp_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the logic analyzer command parser: watches both channels, predicts
// every result from the accepted host bytes and compares it field by field.
// Depends on lacp_pkg and the channel interfaces in lacp_ifs.sv.
module lacp_result_checker
  import lacp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lacp_in_if   in_mon,
  lacp_out_if  out_mon,
  output int   failures,
  output int   pending,
  output int   checked,
  output int   long_cmds
);

  logic [7:0]   open_opcode;
  logic [7:0]   payload [4];
  logic [2:0]   bytes_seen;
  settings_t    live;
  lacp_result_t due_results [$];

  function automatic settings_t default_settings();
    settings_t s;
    s = '0;
    s.sample_divider = 24'(DEF_DIVIDER);
    s.read_samples   = 19'(DEF_SAMPLES);
    s.delay_samples  = 19'(DEF_SAMPLES);
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    failures++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s is 0x%0h, expected 0x%0h",
                                checked, name, got, want));
    end
  endtask

  // The fifth byte of a long command commits its 32-bit little-endian payload.
  task automatic commit_long_command();
    logic [31:0] word;
    logic [18:0] lo_count;
    logic [18:0] hi_count;
    word     = {payload[3], payload[2], payload[1], payload[0]};
    lo_count = 19'({payload[1], payload[0]}) + 19'd1;
    hi_count = 19'({payload[3], payload[2]}) + 19'd1;
    case (open_opcode)
      OP_SET_DIVIDER: live.sample_divider = word[23:0];
      OP_SET_COUNTS: begin
        live.read_samples  = lo_count << 2;
        live.delay_samples = hi_count << 2;
      end
      OP_SET_FLAGS:  live.capture_flags = word;
      OP_TRIG_MASK:  live.trig_mask = word;
      OP_TRIG_VALUE: live.trig_value = word;
      OP_TRIG_SETUP: live.trig_setup = word;
      default: ;
    endcase
    long_cmds++;
  endtask

  task automatic decode_host_byte(input logic [7:0] b);
    lacp_result_t r;
    r.action = ACT_NONE;
    if (bytes_seen != 3'd0) begin
      // Inside a long command every byte is payload, whatever its value.
      payload[2'(bytes_seen - 3'd1)] = b;
      if (bytes_seen == LONG_PAYLOAD) begin
        commit_long_command();
        bytes_seen = 3'd0;
      end else begin
        bytes_seen = bytes_seen + 3'd1;
      end
    end else if (b[7]) begin
      open_opcode = b;
      bytes_seen  = 3'd1;
    end else begin
      case (b)
        SHORT_RESET: begin
          live     = default_settings();
          r.action = ACT_RESET;
        end
        SHORT_RUN:  r.action = ACT_RUN;
        SHORT_ID:   r.action = ACT_ID;
        SHORT_META: r.action = ACT_META;
        default: ;
      endcase
    end
    r.settings = live;
    due_results.push_back(r);
  endtask

  task automatic compare_result();
    lacp_result_t want;
    if (due_results.size() == 0) begin
      report_mismatch("result arrived with no request outstanding");
    end else begin
      want = due_results.pop_front();
      check_field("action", 32'(out_mon.action), 32'(want.action));
      check_field("sample_divider", 32'(out_mon.sample_divider),
                  32'(want.settings.sample_divider));
      check_field("read_samples", 32'(out_mon.read_samples),
                  32'(want.settings.read_samples));
      check_field("delay_samples", 32'(out_mon.delay_samples),
                  32'(want.settings.delay_samples));
      check_field("capture_flags", out_mon.capture_flags, want.settings.capture_flags);
      check_field("trig_mask", out_mon.trig_mask, want.settings.trig_mask);
      check_field("trig_value", out_mon.trig_value, want.settings.trig_value);
      check_field("trig_setup", out_mon.trig_setup, want.settings.trig_setup);
      checked++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      open_opcode = 8'h00;
      payload     = '{default: 8'h00};
      bytes_seen  = 3'd0;
      live        = default_settings();
      due_results.delete();
    end else begin
      // A result shown in the same cycle as its byte would still be matched, since the new
      // request goes to the back of the queue.
      if (in_mon.valid && in_mon.ready) begin
        decode_host_byte(in_mon.host_byte);
      end
      if (out_mon.valid && out_mon.ready) begin
        compare_result();
      end
    end
    pending = due_results.size();
  end

endmodule

>>> verif/logic_analyzer_command_parser_tb.sv
`timescale 1ns / 100ps
// Testbench top for the logic analyzer command parser: clock, reset, host byte stimulus
// and a randomly stalling result receiver; lacp_result_checker does the checking.
// Depends on lacp_pkg, lacp_ifs.sv, lacp_result_checker.sv and the parser RTL.
module logic_analyzer_command_parser_tb;
  import lacp_pkg::*;

  // Roughly this many host bytes are driven in total.
  localparam int ITEM_TARGET = 1300;
  // The last stretch of the run goes without idle cycles on either side.
  localparam int QUIET_TAIL = 150;
  // One long hold-off of the receiver, started once this many bytes have gone in.
  localparam int HOLD_OFF_AFTER = 400;
  localparam int HOLD_OFF_CYCLES = 300;
  // An opcode with bit 7 set that the parser does not know.
  localparam logic [7:0] UNKNOWN_OP = 8'hc3;

  logic clk = 1'b0;
  logic rst_n;

  int sent_count = 0;
  bit quiet = 1'b0;

  int failures;
  int pending;
  int checked;
  int long_cmds;

  lacp_in_if  in_ch ();
  lacp_out_if out_ch ();

  logic_analyzer_command_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lacp_result_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .failures  (failures),
    .pending   (pending),
    .checked   (checked),
    .long_cmds (long_cmds)
  );

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offers one host byte and returns at the falling edge after it was accepted. Must be
  // called at a falling edge. An idle burst, when one is drawn, comes before the byte,
  // so valid gets exactly one assignment per falling edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.host_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
    quiet = (sent_count >= ITEM_TARGET - QUIET_TAIL);
    @(negedge clk);
  endtask

  // A long command is its opcode followed by the 32-bit value, least significant first.
  task automatic send_long(input logic [7:0] opcode, input logic [31:0] word);
    send_byte(opcode);
    for (int i = 0; i < 4; i++) begin
      send_byte(word[8*i +: 8]);
    end
  endtask

  // Payload bytes lean toward all zeros and all ones so the size and mask extremes
  // show up often in the random part.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int pick;
    for (int i = 0; i < 4; i++) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        w[8*i +: 8] = 8'h00;
      end else if (pick == 1) begin
        w[8*i +: 8] = 8'hff;
      end else begin
        w[8*i +: 8] = 8'($urandom_range(0, 255));
      end
    end
    return w;
  endfunction

  function automatic logic [7:0] random_known_opcode();
    logic [7:0] ops [6];
    ops = '{OP_SET_DIVIDER, OP_SET_COUNTS, OP_SET_FLAGS, OP_TRIG_MASK, OP_TRIG_VALUE,
            OP_TRIG_SETUP};
    return ops[$urandom_range(0, 5)];
  endfunction

  function automatic logic [7:0] random_unknown_opcode();
    logic [7:0] op;
    do begin
      op = 8'($urandom_range(128, 255));
    end while (op inside {OP_SET_DIVIDER, OP_SET_COUNTS, OP_SET_FLAGS, OP_TRIG_MASK,
                          OP_TRIG_VALUE, OP_TRIG_SETUP});
    return op;
  endfunction

  // Mostly run, ID and metadata bytes; now and then a random byte with bit 7 clear, which may be any short command.
  function automatic logic [7:0] random_short();
    case ($urandom_range(0, 3))
      0: return SHORT_RUN;
      1: return SHORT_ID;
      2: return SHORT_META;
      default: return 8'($urandom_range(0, 127));
    endcase
  endfunction

  // Stimulus: reset, a directed sequence, then a random mix of mostly well-formed
  // commands with some stray bytes that may open a long command out of turn.
  initial begin
    int pick;
    int guard;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.host_byte = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The run, ID and metadata actions first, plus a byte with no meaning, each
    // against the reset settings.
    send_byte(SHORT_RUN);
    send_byte(SHORT_ID);
    send_byte(SHORT_META);
    send_byte(8'h7f);
    // The divider keeps only its low 24 bits; all-ones sizes give the largest counts.
    send_long(OP_SET_DIVIDER, 32'hffff_ffff);
    send_long(OP_SET_COUNTS, 32'hffff_ffff);
    // An unknown opcode still swallows four bytes, here ones that would otherwise be a
    // reset, a long opcode, a run and a metadata request.
    send_long(UNKNOWN_OP, {SHORT_META, SHORT_RUN, OP_SET_DIVIDER, SHORT_RESET});
    // Reset restores the defaults after the changes above.
    send_byte(SHORT_RESET);
    // Zero size fields give the smallest counts.
    send_long(OP_SET_COUNTS, 32'h0000_0000);

    // Random part.
    while (sent_count < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_long(random_known_opcode(), random_word());
      end else if (pick < 68) begin
        send_long(random_unknown_opcode(), random_word());
      end else if (pick < 90) begin
        send_byte(random_short());
      end else if (pick < 93) begin
        send_byte(SHORT_RESET);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    in_ch.valid <= 1'b0;

    // Drain: wait until every request has produced its result, with a guard against hanging.
    guard = 0;
    while (pending != 0 && guard < 2000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);

    $display("Drove %0d host bytes; %0d results compared, %0d long commands completed.",
             sent_count, checked, long_cmds);
    $display("The receiver held off once for %0d cycles to back the parser up.",
             HOLD_OFF_CYCLES);
    if (pending != 0) begin
      $display("%0d requests never produced a result", pending);
    end
    if (failures == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Result receiver. Ready drops in random bursts, and once for a long stretch while
  // the sender keeps offering bytes, so the output buffer fills and the input stalls.
  initial begin
    bit held_off;
    held_off     = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!quiet && !held_off && sent_count >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Watchdog: the slowest legal run is far below this.
  initial begin
    #2ms;
    $display("Timed out with %0d bytes sent and %0d results pending", sent_count, pending);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
